// ===== rtl/can_bit_timing_solver_unit_macros.svh =====
// ----------------------------------------------------------------------------
// CAN bit timing solver assertion macros
// Shorthand for clocked concurrent checks, reset through arst_n.
// ----------------------------------------------------------------------------
`ifndef CAN_BIT_TIMING_SOLVER_UNIT_MACROS_SVH
`define CAN_BIT_TIMING_SOLVER_UNIT_MACROS_SVH

// same-cycle implication
`define CBTS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cbts check failed");

// next-cycle implication
`define CBTS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cbts check failed");

`endif

// ===== rtl/cbts_pkg.sv =====
// ----------------------------------------------------------------------------
// CAN bit timing solver package
// Widths, search range, register indexes and word types.
// ----------------------------------------------------------------------------
package cbts_pkg;

	localparam int QUANTA_HIGH = 25;
	localparam int QUANTA_LOW  = 8;

	localparam int TQ_W   = $clog2(QUANTA_HIGH + 1);
	localparam int RATE_W = 24;
	localparam int CLK_W  = 32;
	localparam int DEN_W  = RATE_W + TQ_W;
	localparam int PSC_W  = 11;
	localparam int SJW_W  = 8;
	localparam int SJC_W  = (TQ_W > SJW_W) ? TQ_W : SJW_W;
	localparam int DIV_CNT_W = $clog2(CLK_W);

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CLOCK_FREQUENCY = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_PRESCALER   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SJW_LIMIT       = 2'd2;

	localparam logic [CLK_W-1:0] CLOCK_FREQUENCY_RST = '0;
	localparam logic [PSC_W-1:0] MIN_PRESCALER_RST   = 11'd1;
	localparam logic [SJW_W-1:0] SJW_LIMIT_RST       = 8'd16;

	typedef struct packed {
		logic [RATE_W-1:0] bitrate;
		logic [PSC_W-1:0]  prescaler_limit;
	} cbts_in_t;

	typedef struct packed {
		logic             status;
		logic [PSC_W-1:0] prescaler;
		logic [4:0]       quanta_per_bit;
		logic [4:0]       phase_seg1;
		logic [2:0]       phase_seg2;
		logic [2:0]       jump_width;
	} cbts_out_t;

	typedef struct packed {
		logic             done;
		logic [CLK_W-1:0] quotient;
		logic             rem_zero;
	} cbts_div_res_t;

endpackage

// ===== rtl/cbts_div.sv =====
// ----------------------------------------------------------------------------
// CAN bit timing solver divider
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbts_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [cbts_pkg::CLK_W-1:0]  dividend,
	input  logic [cbts_pkg::DEN_W-1:0]  divisor,
	output cbts_pkg::cbts_div_res_t     res
);
	import cbts_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]     rem_q;
	logic [CLK_W-1:0]     quo_q;
	logic [DEN_W-1:0]     div_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           fits;

	assign trial = {rem_q, quo_q[CLK_W-1]};
	assign diff  = trial - {1'b0, div_q};
	assign fits  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
			div_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == DIV_CNT_W'(CLK_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				rem_q  <= '0;
				quo_q  <= dividend;
				div_q  <= divisor;
			end else if (busy_q) begin
				// shift in the next dividend bit, subtract when it fits
				rem_q <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quo_q <= {quo_q[CLK_W-2:0], fits};
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(CLK_W - 1))
					busy_q <= 1'b0;
			end
		end
	end

	assign res.done     = done_q;
	assign res.quotient = quo_q;
	assign res.rem_zero = (rem_q == '0);

endmodule

// ===== rtl/can_bit_timing_solver_unit.sv =====
// ----------------------------------------------------------------------------
// CAN bit timing solver
// Searches quanta-per-bit counts for an exact prescaler and a 75% sample point.
// ----------------------------------------------------------------------------
// Usage:
//   Write clock_frequency, min_prescaler and sjw_limit on the cfg channel
//   (cfg_ready is always high) while no request is in flight.
//   Present a request word on in_data with in_valid; it is taken when in_stall
//   is low. One result word per request leaves on out_data with out_valid.
// Search:
//   Each candidate takes one multiply, one divider load, 32 steps of
//   the shared serial divider and a quotient test. The search runs from the top
//   count down and stops at the first fit. A zero clock or rate gives a no-fit
//   result with no search, as does a search in which all 18 counts fail.
//   in_stall stays high until the result is loaded, so no new request is
//   taken while a search or its result is pending.
// Reset:
//   Registers return to clock 0, min prescaler 1, SJW limit 16; no result
//   is pending and the input channel is open.
// Stall:
//   A result held by out_stall stays in the output register; the next request
//   may still be taken and searched, then waits until the register frees.
// ----------------------------------------------------------------------------
module can_bit_timing_solver_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  cbts_pkg::cbts_in_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output cbts_pkg::cbts_out_t             out_data,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [cbts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbts_pkg::CLK_W-1:0]      cfg_data
);
	import cbts_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_MUL,
		S_START,
		S_WAIT,
		S_DONE
	} state_t;

	localparam bit NO_CANDIDATES = (QUANTA_LOW > QUANTA_HIGH);

	state_t            state_q;
	logic [CLK_W-1:0]  clk_freq_q;
	logic [PSC_W-1:0]  min_psc_q;
	logic [SJW_W-1:0]  sjw_lim_q;
	logic [RATE_W-1:0] rate_q;
	logic [PSC_W-1:0]  plim_q;
	logic [TQ_W-1:0]   tq_q;
	logic [DEN_W-1:0]  denom_q;
	cbts_out_t         res_q;
	cbts_out_t         out_q;
	logic              out_valid_q;

	cbts_div_res_t     div_res;
	logic              div_start;

	// field math for the current count
	logic [TQ_W-1:0]   tqm1;
	logic [TQ_W+1:0]   tqm1_x3;
	logic [TQ_W-1:0]   seg1;
	logic [TQ_W-1:0]   seg2;
	logic [SJC_W-1:0]  seg2_w;
	logic [SJC_W-1:0]  sjw_w;
	logic [SJC_W-1:0]  sj;
	logic              psc_ok;
	cbts_out_t         hit;
	cbts_out_t         miss;
	logic              out_free;

	assign tqm1    = tq_q - 1'b1;
	assign tqm1_x3 = {1'b0, tqm1, 1'b0} + {2'b00, tqm1};
	assign seg1    = tqm1_x3[TQ_W+1:2];
	assign seg2    = tqm1 - seg1;
	assign seg2_w  = SJC_W'(seg2);
	assign sjw_w   = SJC_W'(sjw_lim_q);
	assign sj      = (seg2_w < sjw_w) ? seg2_w : sjw_w;

	assign psc_ok = div_res.rem_zero
		&& (div_res.quotient >= CLK_W'(min_psc_q))
		&& (div_res.quotient <= CLK_W'(plim_q));

	always_comb begin
		hit                = '0;
		hit.status         = 1'b0;
		hit.prescaler      = div_res.quotient[PSC_W-1:0];
		hit.quanta_per_bit = 5'(tq_q);
		hit.phase_seg1     = 5'(seg1);
		hit.phase_seg2     = 3'(seg2);
		hit.jump_width     = 3'(sj);
		miss               = '0;
		miss.status        = 1'b1;
	end

	assign div_start = (state_q == S_START);
	assign out_free  = !out_valid_q || !out_stall;

	cbts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (clk_freq_q),
		.divisor  (denom_q),
		.res      (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			clk_freq_q  <= CLOCK_FREQUENCY_RST;
			min_psc_q   <= MIN_PRESCALER_RST;
			sjw_lim_q   <= SJW_LIMIT_RST;
			rate_q      <= '0;
			plim_q      <= '0;
			tq_q        <= '0;
			denom_q     <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_CLOCK_FREQUENCY: clk_freq_q <= cfg_data;
					CFG_MIN_PRESCALER:   min_psc_q  <= cfg_data[PSC_W-1:0];
					CFG_SJW_LIMIT:       sjw_lim_q  <= cfg_data[SJW_W-1:0];
					default: ;
				endcase
			end

			if (state_q == S_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						rate_q <= in_data.bitrate;
						plim_q <= in_data.prescaler_limit;
						tq_q   <= TQ_W'(QUANTA_HIGH);
						if (in_data.bitrate == '0 || clk_freq_q == '0 || NO_CANDIDATES) begin
							res_q   <= miss;
							state_q <= S_DONE;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					denom_q <= DEN_W'(rate_q) * DEN_W'(tq_q);
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_res.done) begin
						if (psc_ok) begin
							res_q   <= hit;
							state_q <= S_DONE;
						end else if (tq_q == TQ_W'(QUANTA_LOW)) begin
							res_q   <= miss;
							state_q <= S_DONE;
						end else begin
							// step down to the next count
							tq_q    <= tq_q - 1'b1;
							state_q <= S_MUL;
						end
					end
				end
				S_DONE: begin
					// hold until the output register frees
					if (out_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign cfg_ready = 1'b1;

endmodule

// ===== rtl/cbts_checker.sv =====
// ----------------------------------------------------------------------------
// CAN bit timing solver port checker
// Watches the top level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`include "can_bit_timing_solver_unit_macros.svh"

module cbts_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	input  logic                            in_stall,
	input  cbts_pkg::cbts_in_t              in_data,
	input  logic                            out_valid,
	input  logic                            out_stall,
	input  cbts_pkg::cbts_out_t             out_data,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [cbts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cbts_pkg::CLK_W-1:0]      cfg_data
);
	import cbts_pkg::*;

	// a stalled result word holds
	`CBTS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

	// a failed search reports all-zero fields
	`CBTS_ASSERT_NOW(a_fail_zero, out_valid && out_data.status,
		out_data.prescaler == '0 && out_data.quanta_per_bit == '0
		&& out_data.phase_seg1 == '0 && out_data.phase_seg2 == '0
		&& out_data.jump_width == '0)

	// a solution has a nonzero divider and SJW within TSEG2
	`CBTS_ASSERT_NOW(a_hit_sane, out_valid && !out_data.status,
		out_data.prescaler != '0 && out_data.jump_width <= out_data.phase_seg2)

	// a taken request closes the input until its search ends
	`CBTS_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

endmodule

bind can_bit_timing_solver_unit cbts_checker u_cbts_checker (.*);

// ===== tb/can_bit_timing_solver_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN bit timing solver testbench
// A table of directed requests and register writes runs first. Random phases
// follow, each under its own register setting. Most requests are built to
// divide the clock exactly, the rest are noise. Each result word is checked
// field by field against an in-bench solver, or a no-fit word for known bad
// rows. Both channels idle at random, and the receiver once holds off long.
// ----------------------------------------------------------------------------
module can_bit_timing_solver_unit_tb;
	import cbts_pkg::*;

	localparam int CYCLE_LIMIT   = 4_000_000;
	localparam int DRAIN_CYCLES  = 700;
	localparam int PHASES        = 8;
	localparam int PHASE_ITEMS   = 125;
	localparam int IDLE_PCT      = 38;
	localparam int NUM_ROWS      = 26;

	localparam cbts_out_t NO_FIT = cbts_out_t'({1'b1, 27'd0});

	typedef enum logic [1:0] {ROW_SOLVE, ROW_NO_FIT, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t            kind;
		logic [CFG_IDX_W-1:0] index;
		logic [CLK_W-1:0]     value;
		cbts_in_t             word;
	} row_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	cbts_in_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	cbts_out_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CLK_W-1:0]     cfg_data = '0;

	// register shadow for the solver
	logic [CLK_W-1:0] core_freq = CLOCK_FREQUENCY_RST;
	logic [PSC_W-1:0] min_psc  = MIN_PRESCALER_RST;
	logic [SJW_W-1:0] sjw_cap  = SJW_LIMIT_RST;

	cbts_out_t timing_due[$];
	int        mismatch_count = 0;
	int        items_sent = 0;
	int        results_seen = 0;
	int        hold_left = 0;
	int        cycle_count;

	row_t plan [NUM_ROWS] = '{
		'{ROW_NO_FIT, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd500_000, 11'd1024}},
		'{ROW_NO_FIT, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd0, 11'd1024}},
		'{ROW_REG, CFG_CLOCK_FREQUENCY, 32'd80_000_000, '{24'd0, 11'd0}},
		'{ROW_NO_FIT, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd0, 11'd1024}},
		'{ROW_NO_FIT, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd1_000_000, 11'd0}},
		'{ROW_NO_FIT, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd1_000_000, 11'd1}},
		'{ROW_SOLVE, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd1_000_000, 11'd1024}},
		'{ROW_SOLVE, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd500_000, 11'd1024}},
		'{ROW_SOLVE, CFG_CLOCK_FREQUENCY, 32'd0, '{24'hFF_FFFF, 11'h7FF}},
		'{ROW_SOLVE, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd1, 11'h7FF}},
		'{ROW_SOLVE, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd3_200_000, 11'd1}},
		'{ROW_REG, CFG_SJW_LIMIT, 32'd0, '{24'd0, 11'd0}},
		'{ROW_SOLVE, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd3_200_000, 11'd1}},
		'{ROW_REG, CFG_SJW_LIMIT, 32'd255, '{24'd0, 11'd0}},
		'{ROW_SOLVE, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd250_000, 11'd1024}},
		'{ROW_REG, CFG_MIN_PRESCALER, 32'd0, '{24'd0, 11'd0}},
		'{ROW_SOLVE, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd3_200_000, 11'd1}},
		'{ROW_REG, CFG_MIN_PRESCALER, 32'h7FF, '{24'd0, 11'd0}},
		'{ROW_NO_FIT, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd1_000_000, 11'h7FF}},
		'{ROW_REG, CFG_MIN_PRESCALER, 32'd1024, '{24'd0, 11'd0}},
		'{ROW_SOLVE, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd3125, 11'd1024}},
		'{ROW_REG, CFG_CLOCK_FREQUENCY, 32'hFFFF_FFFF, '{24'd0, 11'd0}},
		'{ROW_SOLVE, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd65535, 11'h7FF}},
		'{ROW_SOLVE, CFG_CLOCK_FREQUENCY, 32'd0, '{24'd1, 11'h7FF}},
		'{ROW_REG, CFG_MIN_PRESCALER, 32'd1, '{24'd0, 11'd0}},
		'{ROW_REG, CFG_SJW_LIMIT, 32'd1, '{24'd0, 11'd0}}
	};

	logic [CLK_W-1:0] clock_pool [10] = '{
		32'd80_000_000, 32'd40_000_000, 32'd48_000_000, 32'd24_000_000,
		32'd120_000_000, 32'd160_000_000, 32'd64_000_000, 32'd20_000_000,
		32'd16_000_000, 32'hFFFF_FFFF
	};

	can_bit_timing_solver_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// first count from the top that divides the clock with a prescaler in range
	function automatic cbts_out_t solve_timing(input cbts_in_t w);
		logic [63:0] rate;
		logic [63:0] denom;
		logic [63:0] quot;
		int          s1;
		int          s2;
		int          sj;
		cbts_out_t   r;
		r = NO_FIT;
		rate = 64'(w.bitrate);
		if (rate == 0 || core_freq == 0)
			return r;
		for (int tq = QUANTA_HIGH; tq >= QUANTA_LOW; tq--) begin
			denom = rate * 64'(tq);
			if ((64'(core_freq) % denom) != 0)
				continue;
			quot = 64'(core_freq) / denom;
			if (quot < 64'(min_psc) || quot > 64'(w.prescaler_limit))
				continue;
			s1 = ((tq - 1) * 3) / 4;
			s2 = (tq - 1) - s1;
			sj = (s2 < int'(sjw_cap)) ? s2 : int'(sjw_cap);
			r.status         = 1'b0;
			r.prescaler      = quot[PSC_W-1:0];
			r.quanta_per_bit = 5'(tq);
			r.phase_seg1     = 5'(s1);
			r.phase_seg2     = 3'(s2);
			r.jump_width     = 3'(sj);
			return r;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t: result %0d %s: got %0d, want %0d", $time, results_seen, what, got,
			want);
		mismatch_count++;
	endtask

	task automatic check_result(input cbts_out_t got);
		cbts_out_t want;
		if (timing_due.size() == 0) begin
			report_mismatch("arrived with nothing pending", 32'(got), 32'd0);
			return;
		end
		want = timing_due.pop_front();
		if (got.status != want.status)
			report_mismatch("status", 32'(got.status), 32'(want.status));
		if (got.prescaler != want.prescaler)
			report_mismatch("prescaler", 32'(got.prescaler), 32'(want.prescaler));
		if (got.quanta_per_bit != want.quanta_per_bit)
			report_mismatch("quanta_per_bit", 32'(got.quanta_per_bit),
				32'(want.quanta_per_bit));
		if (got.phase_seg1 != want.phase_seg1)
			report_mismatch("phase_seg1", 32'(got.phase_seg1), 32'(want.phase_seg1));
		if (got.phase_seg2 != want.phase_seg2)
			report_mismatch("phase_seg2", 32'(got.phase_seg2), 32'(want.phase_seg2));
		if (got.jump_width != want.jump_width)
			report_mismatch("jump_width", 32'(got.jump_width), 32'(want.jump_width));
	endtask

	// offer one request word; known_bad skips the solver and expects no fit
	task automatic offer_request(input cbts_in_t w, input bit known_bad);
		while (!(items_sent >= 400 && items_sent < 560) &&
				$urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		timing_due.push_back(known_bad ? NO_FIT : solve_timing(w));
		items_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CLK_W-1:0] val);
		in_valid <= 1'b0;
		@(posedge clk);
		while (timing_due.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_CLOCK_FREQUENCY: core_freq = val;
			CFG_MIN_PRESCALER:   min_psc = val[PSC_W-1:0];
			CFG_SJW_LIMIT:       sjw_cap = val[SJW_W-1:0];
			default: ;
		endcase
	endtask

	// result side: random stall, one long hold-off, one stretch with no stall
	initial begin
		forever begin
			@(posedge clk);
			if (!arst_n)
				continue;
			if (out_valid && !out_stall) begin
				results_seen++;
				check_result(out_data);
				if (results_seen == 60)
					hold_left = 4000;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (results_seen >= 420 && results_seen < 600) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("can_bit_timing_solver_unit_tb: errors");
		$finish;
	end

	initial begin : stimulus
		cbts_in_t         w;
		logic [CLK_W-1:0] clk_pick;
		logic [PSC_W-1:0] min_pick;
		logic [SJW_W-1:0] sjw_pick;
		int unsigned      tq;
		int unsigned      psc;
		int unsigned      lo;
		int unsigned      plim;
		logic [CLK_W-1:0] quot;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			case (plan[i].kind)
				ROW_REG:    write_reg(plan[i].index, plan[i].value);
				ROW_NO_FIT: offer_request(plan[i].word, 1'b1);
				default:    offer_request(plan[i].word, 1'b0);
			endcase
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			clk_pick = (phase == 5) ? 32'($urandom) : clock_pool[$urandom_range(0, 9)];
			case (phase)
				1:       min_pick = 11'd0;
				3:       min_pick = 11'h7FF;
				5:       min_pick = 11'd1024;
				default: min_pick = 11'($urandom_range(1, 8));
			endcase
			case (phase)
				2:       sjw_pick = 8'd0;
				4:       sjw_pick = 8'd255;
				6:       sjw_pick = 8'd128;
				default: sjw_pick = 8'($urandom_range(1, 8));
			endcase
			write_reg(CFG_CLOCK_FREQUENCY, clk_pick);
			write_reg(CFG_MIN_PRESCALER, 32'(min_pick));
			write_reg(CFG_SJW_LIMIT, 32'(sjw_pick));

			repeat (PHASE_ITEMS) begin
				w.bitrate = 24'($urandom);
				w.prescaler_limit = 11'($urandom_range(0, 2047));
				if ($urandom_range(0, 99) < 25) begin
					if ($urandom_range(0, 9) == 0)
						w.bitrate = '0;
				end else begin
					// build a rate that divides the clock exactly for some count
					lo = (min_psc == 0) ? 1 : min_psc;
					for (int k = 0; k < 8; k++) begin
						tq  = $urandom_range(QUANTA_LOW, QUANTA_HIGH);
						psc = lo + $urandom_range(0, 31);
						if (psc > 2047)
							psc = 2047;
						if (core_freq % (tq * psc) != 0)
							continue;
						quot = core_freq / (tq * psc);
						if (quot == 0 || quot > 32'hFF_FFFF)
							continue;
						case ($urandom_range(0, 3))
							0:       plim = psc - 1;
							1:       plim = psc;
							default: plim = psc + $urandom_range(0, 64);
						endcase
						if (plim > 2047)
							plim = 2047;
						w.bitrate = quot[RATE_W-1:0];
						w.prescaler_limit = 11'(plim);
						break;
					end
				end
				offer_request(w, 1'b0);
			end
		end

		in_valid <= 1'b0;
		while (timing_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("can_bit_timing_solver_unit_tb: clean");
		else
			$display("can_bit_timing_solver_unit_tb: errors");
		$finish;
	end

endmodule
